FILE: hdl/dcd_pkg.sv
`default_nettype none

package dcd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned KIND_W  = 3;

    localparam logic [BYTE_W-1:0] PAYLOAD_MASK = 8'h7F;
    localparam logic [BYTE_W-1:0] CONT_BIT     = 8'h80;

    // section codes double as the entry_kind of a result
    typedef enum logic [KIND_W-1:0] {
        SEC_STATIC   = 3'd0,
        SEC_INSTANCE = 3'd1,
        SEC_DIRECT   = 3'd2,
        SEC_VIRTUAL  = 3'd3,
        SEC_HEADER   = 3'd4,
        SEC_IDLE     = 3'd5
    } t_section;

    typedef struct packed {
        logic [KIND_W-1:0]  entry_kind;
        logic [VALUE_W-1:0] member_index;
        logic [VALUE_W-1:0] access_bits;
        logic [VALUE_W-1:0] code_offset;
        logic [VALUE_W-1:0] static_total;
        logic [VALUE_W-1:0] instance_total;
        logic [VALUE_W-1:0] direct_total;
        logic [VALUE_W-1:0] virtual_total;
        logic               last;
        logic               overlong_error;
    } t_result;

endpackage

`default_nettype wire

FILE: hdl/dcd_if.sv
`default_nettype none

interface dcd_byte_if;
    logic                      valid;
    logic                      ready;
    logic [dcd_pkg::BYTE_W-1:0] byte_value;
    logic                      start_class;

    modport source (output valid, output byte_value, output start_class, input ready);
    modport sink   (input valid, input byte_value, input start_class, output ready);
endinterface

interface dcd_entry_if;
    logic                        valid;
    logic                        ready;
    logic [dcd_pkg::KIND_W-1:0]  entry_kind;
    logic [dcd_pkg::VALUE_W-1:0] member_index;
    logic [dcd_pkg::VALUE_W-1:0] access_bits;
    logic [dcd_pkg::VALUE_W-1:0] code_offset;
    logic [dcd_pkg::VALUE_W-1:0] static_total;
    logic [dcd_pkg::VALUE_W-1:0] instance_total;
    logic [dcd_pkg::VALUE_W-1:0] direct_total;
    logic [dcd_pkg::VALUE_W-1:0] virtual_total;
    logic                        last;
    logic                        overlong_error;

    modport source (
        output valid, output entry_kind, output member_index, output access_bits,
        output code_offset, output static_total, output instance_total,
        output direct_total, output virtual_total, output last, output overlong_error,
        input ready
    );
    modport sink (
        input valid, input entry_kind, input member_index, input access_bits,
        input code_offset, input static_total, input instance_total,
        input direct_total, input virtual_total, input last, input overlong_error,
        output ready
    );
endinterface

`default_nettype wire

FILE: hdl/dcd_decode.sv
`default_nettype none

module dcd_decode (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic [dcd_pkg::BYTE_W-1:0]   i_byte_value,
    input  wire logic                         i_start_class,
    output logic                              o_res_valid,
    output dcd_pkg::t_result                  o_res
);
    import dcd_pkg::*;

    t_section           r_section, n_section;
    logic [VALUE_W-1:0] r_accum, n_accum;
    logic [2:0]         r_pos, n_pos;
    logic [1:0]         r_slot, n_slot;
    logic [VALUE_W-1:0] r_counts [4];
    logic [VALUE_W-1:0] n_counts [4];
    logic [VALUE_W-1:0] r_left, n_left;
    logic [VALUE_W-1:0] r_run, n_run;
    logic [VALUE_W-1:0] r_held_idx, n_held_idx;
    logic [VALUE_W-1:0] r_held_flags, n_held_flags;

    t_section           e_sec;
    logic [VALUE_W-1:0] e_accum;
    logic [2:0]         e_pos;
    logic [1:0]         e_slot;
    logic [VALUE_W-1:0] shifted;
    logic [VALUE_W-1:0] acc_n;
    logic [VALUE_W-1:0] left_dec;
    logic [3:0]         nz_hdr;
    logic [3:0]         nz_cur;
    logic [2:0]         hdr_hit;
    logic [2:0]         ent_hit;
    logic [KIND_W-1:0]  next_from;

    // first non-empty section at or after from: {found, index}
    function automatic logic [2:0] seek(input logic [KIND_W-1:0] from, input logic [3:0] nz);
        logic [2:0] r;
        r = 3'b000;
        for (int s = 3; s >= 0; s--) begin
            if (nz[s] && (from <= KIND_W'(s))) begin
                r = {1'b1, 2'(s)};
            end
        end
        return r;
    endfunction

    // a start byte clears the decoding state before it is used
    assign e_sec   = i_start_class ? SEC_HEADER : r_section;
    assign e_accum = i_start_class ? '0 : r_accum;
    assign e_pos   = i_start_class ? '0 : r_pos;
    assign e_slot  = i_start_class ? '0 : r_slot;

    always_comb begin
        unique case (e_pos)
            3'd0:    shifted = VALUE_W'(i_byte_value & PAYLOAD_MASK);
            3'd1:    shifted = VALUE_W'(i_byte_value & PAYLOAD_MASK) << 7;
            3'd2:    shifted = VALUE_W'(i_byte_value & PAYLOAD_MASK) << 14;
            3'd3:    shifted = VALUE_W'(i_byte_value & PAYLOAD_MASK) << 21;
            default: shifted = VALUE_W'(i_byte_value & PAYLOAD_MASK) << 28;
        endcase
    end

    assign acc_n     = e_accum | shifted;
    assign left_dec  = r_left - VALUE_W'(1);
    assign nz_hdr    = {acc_n != '0, r_counts[2] != '0, r_counts[1] != '0, r_counts[0] != '0};
    assign nz_cur    = {r_counts[3] != '0, r_counts[2] != '0, r_counts[1] != '0,
                        r_counts[0] != '0};
    assign hdr_hit   = seek(KIND_W'(SEC_STATIC), nz_hdr);
    assign next_from = KIND_W'(e_sec) + KIND_W'(1);
    assign ent_hit   = seek(next_from, nz_cur);

    always_comb begin
        n_section    = r_section;
        n_accum      = r_accum;
        n_pos        = r_pos;
        n_slot       = r_slot;
        n_counts     = r_counts;
        n_left       = r_left;
        n_run        = r_run;
        n_held_idx   = r_held_idx;
        n_held_flags = r_held_flags;
        o_res_valid  = 1'b0;
        o_res        = '0;

        if (i_en && (e_sec != SEC_IDLE)) begin
            n_section = e_sec;
            n_accum   = e_accum;
            n_pos     = e_pos;
            n_slot    = e_slot;
            if (i_byte_value[7]) begin
                if (e_pos == 3'd4) begin
                    // overlong value ends the class
                    o_res_valid          = 1'b1;
                    o_res.entry_kind     = KIND_W'(e_sec);
                    o_res.last           = 1'b1;
                    o_res.overlong_error = 1'b1;
                    n_section            = SEC_IDLE;
                end else begin
                    n_accum = acc_n;
                    n_pos   = e_pos + 3'd1;
                end
            end else begin
                n_accum = '0;
                n_pos   = '0;
                if (e_sec == SEC_HEADER) begin
                    n_counts[e_slot] = acc_n;
                    if (e_slot != 2'd3) begin
                        n_slot = e_slot + 2'd1;
                    end else begin
                        o_res_valid          = 1'b1;
                        o_res.entry_kind     = KIND_W'(SEC_HEADER);
                        o_res.static_total   = r_counts[0];
                        o_res.instance_total = r_counts[1];
                        o_res.direct_total   = r_counts[2];
                        o_res.virtual_total  = acc_n;
                        o_res.last           = !hdr_hit[2];
                        if (hdr_hit[2]) begin
                            n_section = t_section'({1'b0, hdr_hit[1:0]});
                            n_left    = (hdr_hit[1:0] == 2'd3) ? acc_n : r_counts[hdr_hit[1:0]];
                            n_run     = '0;
                            n_slot    = '0;
                        end else begin
                            n_section = SEC_IDLE;
                        end
                    end
                end else if (e_slot == 2'd0) begin
                    n_held_idx = r_run + acc_n;
                    n_slot     = 2'd1;
                end else if ((e_slot == 2'd1) && (e_sec >= SEC_DIRECT)) begin
                    n_held_flags = acc_n;
                    n_slot       = 2'd2;
                end else begin
                    o_res_valid        = 1'b1;
                    o_res.entry_kind   = KIND_W'(e_sec);
                    o_res.member_index = r_held_idx;
                    o_res.access_bits  = (e_sec >= SEC_DIRECT) ? r_held_flags : acc_n;
                    o_res.code_offset  = (e_sec >= SEC_DIRECT) ? acc_n : '0;
                    n_run              = r_held_idx;
                    n_slot             = '0;
                    n_left             = left_dec;
                    if (left_dec == '0) begin
                        o_res.last = !ent_hit[2];
                        if (ent_hit[2]) begin
                            n_section = t_section'({1'b0, ent_hit[1:0]});
                            n_left    = r_counts[ent_hit[1:0]];
                            n_run     = '0;
                        end else begin
                            n_section = SEC_IDLE;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_section <= SEC_IDLE;
            r_accum   <= '0;
            r_pos     <= '0;
            r_slot    <= '0;
        end else begin
            r_section <= n_section;
            r_accum   <= n_accum;
            r_pos     <= n_pos;
            r_slot    <= n_slot;
        end
        r_counts     <= n_counts;
        r_left       <= n_left;
        r_run        <= n_run;
        r_held_idx   <= n_held_idx;
        r_held_flags <= n_held_flags;
    end

endmodule

`default_nettype wire

FILE: hdl/dex_class_data_decoder_core.sv
// class data item decoder
//
// i_in carries the bytes of a class_data_item, one per transfer, with
// start_class set on the first byte of each item. o_out carries one result
// per decoded header or member entry; last marks the final result of an
// item and overlong_error flags a LEB128 value longer than five bytes.
//
// a byte goes into an input register at its transfer and is decoded from there,
// once the result register is free, straight into the result register, from
// which a result is offered on o_out.
// throughput is one byte per cycle unless o_out stalls, set by the single pass
// from the input register through the decode logic into the result register.
//
// after reset the block is idle and drops bytes until one arrives with
// start_class set. when o_out stalls with a result held, an empty input register
// still takes one more byte; i_in.ready then drops until the result leaves.
`default_nettype none

module dex_class_data_decoder_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dcd_byte_if.sink   i_in,
    dcd_entry_if.source o_out
);
    import dcd_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_start;
    logic              r_out_valid;
    t_result           r_out;
    logic              adv;
    logic              res_valid;
    t_result           res;

    // the input register moves on whenever the result register is free
    assign adv        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || adv;

    dcd_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (adv),
        .i_byte_value  (r_in_byte),
        .i_start_class (r_in_start),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (adv) begin
                r_out_valid <= res_valid;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (i_in.valid && i_in.ready) begin
            r_in_byte  <= i_in.byte_value;
            r_in_start <= i_in.start_class;
        end
        if (adv && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.entry_kind     = r_out.entry_kind;
    assign o_out.member_index   = r_out.member_index;
    assign o_out.access_bits    = r_out.access_bits;
    assign o_out.code_offset    = r_out.code_offset;
    assign o_out.static_total   = r_out.static_total;
    assign o_out.instance_total = r_out.instance_total;
    assign o_out.direct_total   = r_out.direct_total;
    assign o_out.virtual_total  = r_out.virtual_total;
    assign o_out.last           = r_out.last;
    assign o_out.overlong_error = r_out.overlong_error;

endmodule

`default_nettype wire
